/* design/pts_pkg.sv */
// ----------------------------------------------------------------------------
// PWM throttle slew limiter package
// Shared widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Field widths
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned MIU_W   = 6;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_A_W = 2;

  // Default number of motor slots
  localparam int unsigned MOTOR_COUNT_DEF = 32;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_PWM_MIN  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_PWM_MAX  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_STEP = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_MIU      = 2'd3;

  // Register reset values
  localparam logic [WIDTH_W-1:0] PWM_MIN_RST  = 16'd1000;
  localparam logic [WIDTH_W-1:0] PWM_MAX_RST  = 16'd2000;
  localparam logic [THR_W-1:0]   MAX_STEP_RST = 16'd32768;
  localparam logic [MIU_W-1:0]   MIU_RST      = 6'd4;

  // Q1.15 full scale
  localparam logic [THR_W-1:0] FULL_THROTTLE = 16'd32768;

  // Quotient bits of the divider (quotient is always below 2^15)
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned DCNT_W    = 4;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch input transaction, start state read
    logic prep;      // classify, load divider
    logic div_step;  // one restoring division step
    logic finish;    // clamp, store, load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;  // width strictly between min and max, index valid
    logic div_last;  // current division step is the last
    logic out_busy;  // output register holds an untaken result
  } status_t;

endpackage

/* design/pts_ctrl.sv */
// ----------------------------------------------------------------------------
// PWM throttle slew limiter controller
// Sequences accept, classify, divide and finish for one transaction at a time.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  pts_pkg::status_t status_i,
  output pts_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/pts_datapath.sv */
// ----------------------------------------------------------------------------
// PWM throttle slew limiter datapath
// Configuration registers, per-motor throttle store, serial divider, slew
// clamp and output register.
// ----------------------------------------------------------------------------
module pts_datapath #(
  parameter int unsigned MOTOR_COUNT = pts_pkg::MOTOR_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::CFG_A_W-1:0]  cfg_idx_i,
  input  logic [pts_pkg::CFG_W-1:0]    cfg_data_i,
  // input fields
  input  logic [pts_pkg::IDX_W-1:0]    in_idx_i,
  input  logic [pts_pkg::WIDTH_W-1:0]  in_width_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pts_pkg::IDX_W-1:0]    out_idx_o,
  output logic [pts_pkg::THR_W-1:0]    out_thr_o,
  output logic                         out_lim_o,
  output logic                         out_err_o,
  // control
  input  pts_pkg::cmd_t                cmd_i,
  output pts_pkg::status_t             status_o
);

  localparam int unsigned AW  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [8:0]  MCW = 9'(MOTOR_COUNT);

  // configuration registers
  logic [pts_pkg::WIDTH_W-1:0] pwm_min_q, pwm_max_q;
  logic [pts_pkg::THR_W-1:0]   max_step_q;
  logic [pts_pkg::MIU_W-1:0]   miu_q;

  // transaction registers
  logic [pts_pkg::IDX_W-1:0]   idx_q;
  logic [pts_pkg::WIDTH_W-1:0] width_q;
  logic                        err_q;
  logic [pts_pkg::WIDTH_W-1:0] span_q, rem_q;
  logic [pts_pkg::THR_W-1:0]   tgt_q;
  logic [pts_pkg::DCNT_W-1:0]  cnt_q;

  // throttle store with valid bits
  logic [pts_pkg::THR_W-1:0]   mem_q [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0]      vld_q;
  logic [pts_pkg::THR_W-1:0]   rd_q;
  logic                        rd_vld_q;

  // output register
  logic                        ov_q;
  logic [pts_pkg::IDX_W-1:0]   oidx_q;
  logic [pts_pkg::THR_W-1:0]   othr_q;
  logic                        olim_q, oerr_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_min_q  <= pts_pkg::PWM_MIN_RST;
      pwm_max_q  <= pts_pkg::PWM_MAX_RST;
      max_step_q <= pts_pkg::MAX_STEP_RST;
      miu_q      <= pts_pkg::MIU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pts_pkg::REG_PWM_MIN:  pwm_min_q  <= cfg_data_i;
        pts_pkg::REG_PWM_MAX:  pwm_max_q  <= cfg_data_i;
        pts_pkg::REG_MAX_STEP: max_step_q <= cfg_data_i;
        pts_pkg::REG_MIU:      miu_q      <= cfg_data_i[pts_pkg::MIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Classification of the latched item
  logic idx_bad, low, high;
  assign idx_bad = ({1'b0, idx_q} >= miu_q) || (9'(idx_q) >= MCW);
  assign low     = (width_q <= pwm_min_q);
  assign high    = (width_q >= pwm_max_q);

  assign status_o.need_div = !idx_bad && !low && !high;
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_busy = ov_q && !out_ready_i;

  // One restoring division step
  logic [pts_pkg::WIDTH_W:0]   rem_sh;
  logic                        q_bit;
  logic [pts_pkg::WIDTH_W:0]   rem_sub;
  assign rem_sh  = {rem_q, 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, span_q});
  assign rem_sub = rem_sh - {1'b0, span_q};

  // Latch item, classify, divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q   <= in_idx_i;
      width_q <= in_width_i;
    end
    if (cmd_i.prep) begin
      err_q  <= idx_bad;
      span_q <= pwm_max_q - pwm_min_q;
      rem_q  <= width_q - pwm_min_q;
      cnt_q  <= pts_pkg::DCNT_W'(pts_pkg::DIV_STEPS - 1);
      tgt_q  <= (low || idx_bad) ? '0 : (high ? pts_pkg::FULL_THROTTLE : '0);
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_sub[pts_pkg::WIDTH_W-1:0] : rem_sh[pts_pkg::WIDTH_W-1:0];
      tgt_q <= {tgt_q[pts_pkg::THR_W-2:0], q_bit};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Slew clamp
  logic [pts_pkg::THR_W-1:0] prev;
  logic [pts_pkg::THR_W:0]   up_d, dn_d, sum_u, dif_d;
  logic                      clamp_up, clamp_dn;
  logic [pts_pkg::THR_W-1:0] result;
  assign prev     = rd_vld_q ? rd_q : '0;
  assign up_d     = {1'b0, tgt_q} - {1'b0, prev};
  assign dn_d     = {1'b0, prev} - {1'b0, tgt_q};
  assign clamp_up = (tgt_q > prev) && (up_d > {1'b0, max_step_q});
  assign clamp_dn = (prev > tgt_q) && (dn_d > {1'b0, max_step_q});
  assign sum_u    = {1'b0, prev} + {1'b0, max_step_q};
  assign dif_d    = {1'b0, prev} - {1'b0, max_step_q};
  always_comb begin
    if (clamp_up) begin
      result = sum_u[pts_pkg::THR_W-1:0];
    end else if (clamp_dn) begin
      result = dif_d[pts_pkg::THR_W-1:0];
    end else begin
      result = tgt_q;
    end
  end

  // Throttle store: registered read on accept, write on finish
  logic [AW-1:0] rd_addr, wr_addr;
  assign rd_addr = AW'(in_idx_i);
  assign wr_addr = AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.finish && !err_q) begin
      mem_q[wr_addr] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.finish && !err_q) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.finish) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      oidx_q <= idx_q;
      othr_q <= err_q ? '0 : result;
      olim_q <= !err_q && (clamp_up || clamp_dn);
      oerr_q <= err_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_idx_o   = oidx_q;
  assign out_thr_o   = othr_q;
  assign out_lim_o   = olim_q;
  assign out_err_o   = oerr_q;

endmodule

/* design/pwm_throttle_slew_limiter_unit.sv */
// ----------------------------------------------------------------------------
// PWM throttle slew limiter
// Maps a motor's PWM pulse width to a Q1.15 throttle and limits its change
// per update against that motor's stored throttle.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A width strictly between the
// minimum and maximum passes accept, classify, 15 steps of the serial
// restoring divider and finish; one at or outside the limits, or a rejected
// index, skips the divider. The divider sets the rate. A new input is taken
// while the previous result still waits in the output register. The
// per-motor throttle store is cleared by reset at once through one valid bit
// per entry; no clearing pass is needed. The user must write configuration
// through a plain write port while idle; the block does not enforce it.
module pwm_throttle_slew_limiter_unit #(
  parameter int unsigned MOTOR_COUNT = pts_pkg::MOTOR_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [pts_pkg::CFG_A_W-1:0] cfg_idx_i,
  input  logic [pts_pkg::CFG_W-1:0]   cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // motor_index[4:0], pulse_width[20:5]
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // motor_echo[4:0], throttle[20:5],
                                                     // slew_limited[21]
  output logic                        m_axis_tuser   // index_error
);

  pts_pkg::cmd_t    cmd;
  pts_pkg::status_t status;

  logic [pts_pkg::IDX_W-1:0] out_idx;
  logic [pts_pkg::THR_W-1:0] out_thr;
  logic                      out_lim;

  pts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  pts_datapath #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_idx_i    (s_axis_tdata[4:0]),
    .in_width_i  (s_axis_tdata[20:5]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (out_idx),
    .out_thr_o   (out_thr),
    .out_lim_o   (out_lim),
    .out_err_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {2'b00, out_lim, out_thr, out_idx};

endmodule

/* sim/pwm_throttle_slew_limiter_unit_tb.sv */
// ----------------------------------------------------------------------------
// PWM throttle slew limiter testbench
// Drives motor/pulse-width transactions through the input stream, predicts
// each throttle result with a cycle-free model of the mapping and slew clamp,
// and checks every result in order, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module pwm_throttle_slew_limiter_unit_tb;

  localparam int unsigned MOTORS    = 32;
  localparam int unsigned PHASES    = 12;
  localparam int unsigned PHASE_LEN = 100;

  // One predicted throttle result
  typedef struct packed {
    logic [pts_pkg::IDX_W-1:0] motor;
    logic [pts_pkg::THR_W-1:0] throttle;
    logic                      limited;
    logic                      idx_err;
  } throttle_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the limit settings, the per-motor throttle memory and
  // the results still owed by the block
  // --------------------------------------------------------------------------
  class throttle_scoreboard;
    logic [pts_pkg::WIDTH_W-1:0] min_width;
    logic [pts_pkg::WIDTH_W-1:0] max_width;
    logic [pts_pkg::THR_W-1:0]   max_step;
    logic [pts_pkg::MIU_W-1:0]   motors_used;
    logic [pts_pkg::THR_W-1:0]   motor_throttle[MOTORS];
    throttle_result_t            owed_results[$];
    int                          fail_count;
    int                          checked_count;

    function new();
      min_width   = pts_pkg::PWM_MIN_RST;
      max_width   = pts_pkg::PWM_MAX_RST;
      max_step    = pts_pkg::MAX_STEP_RST;
      motors_used = pts_pkg::MIU_RST;
      foreach (motor_throttle[i]) motor_throttle[i] = '0;
      fail_count    = 0;
      checked_count = 0;
    endfunction

    function void set_limits(logic [pts_pkg::WIDTH_W-1:0] lo,
                             logic [pts_pkg::WIDTH_W-1:0] hi,
                             logic [pts_pkg::THR_W-1:0] stp,
                             logic [pts_pkg::MIU_W-1:0] miu);
      min_width   = lo;
      max_width   = hi;
      max_step    = stp;
      motors_used = miu;
    endfunction

    // Map a valid index's width to a target, clamp against the stored throttle, store it
    function void note_pulse(logic [pts_pkg::IDX_W-1:0] idx,
                             logic [pts_pkg::WIDTH_W-1:0] width);
      throttle_result_t res;
      logic [31:0]      target;
      logic [31:0]      prev;
      res.motor    = idx;
      res.throttle = '0;
      res.limited  = 1'b0;
      res.idx_err  = 1'b0;
      if ({1'b0, idx} >= motors_used) begin
        res.idx_err = 1'b1;
      end else begin
        if (width <= min_width) begin
          target = 32'd0;
        end else if (width >= max_width) begin
          target = 32'(pts_pkg::FULL_THROTTLE);
        end else begin
          target = (32'(width - min_width) * 32'd32768) / 32'(max_width - min_width);
        end
        prev = 32'(motor_throttle[idx]);
        if (target > prev && target - prev > 32'(max_step)) begin
          res.throttle = pts_pkg::THR_W'(prev + 32'(max_step));
          res.limited  = 1'b1;
        end else if (prev > target && prev - target > 32'(max_step)) begin
          res.throttle = pts_pkg::THR_W'(prev - 32'(max_step));
          res.limited  = 1'b1;
        end else begin
          res.throttle = pts_pkg::THR_W'(target);
        end
        motor_throttle[idx] = res.throttle;
      end
      owed_results.push_back(res);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [23:0] data, logic user);
      throttle_result_t want;
      throttle_result_t got;
      got.motor    = data[4:0];
      got.throttle = data[20:5];
      got.limited  = data[21];
      got.idx_err  = user;
      checked_count++;
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result motor %0d throttle %0d", got.motor,
                   got.throttle);
        return;
      end
      want = owed_results.pop_front();
      if (got.motor !== want.motor || got.throttle !== want.throttle ||
          got.limited !== want.limited || got.idx_err !== want.idx_err) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR exp/act: motor %0d/%0d throttle %0d/%0d limited %0d/%0d err %0d/%0d",
                   want.motor, got.motor, want.throttle, got.throttle,
                   want.limited, got.limited, want.idx_err, got.idx_err);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pts_pkg::CFG_A_W-1:0]   cfg_idx_i;
  logic [pts_pkg::CFG_W-1:0]     cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata;   // motor_index[4:0], pulse_width[20:5]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [23:0]                   m_axis_tdata;   // motor_echo[4:0], throttle[20:5],
                                                 // slew_limited[21]
  logic                          m_axis_tuser;   // index_error

  throttle_scoreboard sb;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 pulse_count;

  pwm_throttle_slew_limiter_unit #(
    .MOTOR_COUNT(MOTORS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Generate the clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bound the run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Take result transactions and stall at random
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one pulse transaction, idle first at random, note it on acceptance
  task automatic send_pulse(input logic [pts_pkg::IDX_W-1:0] idx,
                            input logic [pts_pkg::WIDTH_W-1:0] width);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, width, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pulse(idx, width);
    pulse_count++;
  endtask

  // Drain the block, then write all four registers back to back
  task automatic write_limits(input logic [pts_pkg::WIDTH_W-1:0] lo,
                              input logic [pts_pkg::WIDTH_W-1:0] hi,
                              input logic [pts_pkg::THR_W-1:0] stp,
                              input logic [pts_pkg::MIU_W-1:0] miu);
    logic [pts_pkg::CFG_W-1:0]   vals[4];
    logic [pts_pkg::CFG_A_W-1:0] regs[4];
    vals = '{lo, hi, stp, pts_pkg::CFG_W'(miu)};
    regs = '{pts_pkg::REG_PWM_MIN, pts_pkg::REG_PWM_MAX, pts_pkg::REG_MAX_STEP,
             pts_pkg::REG_MIU};
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.set_limits(lo, hi, stp, miu);
    @(posedge clk_i);
  endtask

  // Pick a width: mostly around the mapping span, some noise and edges
  function automatic logic [pts_pkg::WIDTH_W-1:0] pick_width(input int lo_w, input int hi_w);
    int sel;
    int a;
    int b;
    sel = $urandom_range(99);
    a   = (lo_w > 50) ? lo_w - 50 : 0;
    b   = (hi_w < 65485) ? hi_w + 50 : 65535;
    if (sel < 70) return pts_pkg::WIDTH_W'($urandom_range(b, a));
    if (sel < 85) return pts_pkg::WIDTH_W'($urandom_range(65535, 0));
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return pts_pkg::WIDTH_W'(lo_w);
      3: return pts_pkg::WIDTH_W'(hi_w);
      4: return pts_pkg::WIDTH_W'((lo_w < 65535) ? lo_w + 1 : lo_w);
      default: return pts_pkg::WIDTH_W'((hi_w > 0) ? hi_w - 1 : 0);
    endcase
  endfunction

  // Main stimulus
  initial begin
    logic [pts_pkg::WIDTH_W-1:0] lo;
    logic [pts_pkg::WIDTH_W-1:0] hi;
    logic [pts_pkg::THR_W-1:0]   stp;
    logic [pts_pkg::MIU_W-1:0]   miu;
    logic [pts_pkg::IDX_W-1:0]   idx;
    int                          span_lo;
    int                          span_hi;
    int                          idx_top;

    sb            = new();
    pulse_count   = 0;
    send_idle_pct = 13;
    recv_idle_pct = 82;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = pts_pkg::REG_PWM_MIN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: below, at and above both width bounds, rejected indexes
    send_pulse(5'd0, 16'd0);
    send_pulse(5'd0, 16'd1000);
    send_pulse(5'd0, 16'd1001);
    send_pulse(5'd1, 16'd1500);
    send_pulse(5'd1, 16'd1999);
    send_pulse(5'd2, 16'd2000);
    send_pulse(5'd3, 16'd65535);
    send_pulse(5'd4, 16'd1500);
    send_pulse(5'd31, 16'd65535);

    // Clamp upward and downward
    write_limits(16'd1000, 16'd2000, 16'd4096, 6'd32);
    send_pulse(5'd2, 16'd0);
    send_pulse(5'd31, 16'd65535);
    send_pulse(5'd0, 16'd1750);

    // Maximum below minimum, zero step, a single motor in use
    write_limits(16'd3000, 16'd1000, 16'd0, 6'd1);
    send_pulse(5'd0, 16'd3000);
    send_pulse(5'd0, 16'd3001);
    send_pulse(5'd1, 16'd500);

    // Equal bounds, a step that never clamps, every index accepted
    write_limits(16'd1500, 16'd1500, 16'hFFFF, 6'd63);
    send_pulse(5'd31, 16'd1500);
    send_pulse(5'd30, 16'd1501);

    // No motors in use: reject everything
    write_limits(16'd0, 16'hFFFF, 16'd32768, 6'd0);
    send_pulse(5'd0, 16'd65535);

    // Widest span: truncation at both ends
    write_limits(16'd0, 16'hFFFF, 16'd32768, 6'd32);
    send_pulse(5'd5, 16'd1);
    send_pulse(5'd5, 16'd65534);
    send_pulse(5'd5, 16'd65535);
    send_pulse(5'd6, 16'd32768);

    // Random phases: four per idling profile
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 4) ? 13 : (p < 8) ? 82 : 0;
      recv_idle_pct = (p < 4) ? 82 : (p < 8) ? 13 : 0;
      lo  = (p == 3) ? 16'd0 : (p == 7) ? 16'hFFFF :
            pts_pkg::WIDTH_W'($urandom_range(1500, 500));
      hi  = (p == 3) ? 16'hFFFF : (p == 7) ? 16'd0 : (p == 5) ? lo :
            pts_pkg::WIDTH_W'(lo + $urandom_range(2000, 1));
      stp = (p % 4 == 0) ? 16'hFFFF : (p == 2) ? 16'd0 : (p == 6) ? 16'd32768 :
            pts_pkg::THR_W'($urandom_range(8000, 1));
      miu = (p == 9) ? 6'd0 : (p == 10) ? 6'd63 : (p == 1) ? 6'd1 :
            pts_pkg::MIU_W'($urandom_range(32, 1));
      write_limits(lo, hi, stp, miu);
      span_lo = (lo < hi) ? int'(lo) : int'(hi);
      span_hi = (lo < hi) ? int'(hi) : int'(lo);
      idx_top = (miu > 32) ? 31 : int'(miu) - 1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (idx_top >= 0 && $urandom_range(99) < 85)
          idx = pts_pkg::IDX_W'($urandom_range(idx_top, 0));
        else
          idx = pts_pkg::IDX_W'($urandom_range(31, 0));
        send_pulse(idx, pick_width(span_lo, span_hi));
      end
    end

    // Drain, then allow the block's latency before the verdict
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.owed_results.size() != 0) begin
      sb.fail_count += sb.owed_results.size();
      $display("ERROR: %0d results never arrived", sb.owed_results.size());
    end

    $display("Sent %0d pulse transactions over %0d limit settings and three idling profiles,",
             pulse_count, PHASES + 6);
    $display("checked %0d throttle results, %0d failures", sb.checked_count, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
